/* rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every rising edge of clk outside reset.
`define ASSERT_AR(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// The condition must never be true at a rising edge of clk outside reset.
`define ASSERT_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

`endif

/* rtl/bsag_pkg.sv */
// ----------------------------------------------------------------------------
// Block scatter address generator package
// Beat types, register indexes and sizing constants shared by all modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package bsag_pkg;

	localparam int BLOCK_SIDE = 4;
	localparam int SIDE_W     = 2;
	localparam int BLK_W      = 44;
	localparam int SLOT_W     = 16;
	localparam int LEN_W      = 17;
	localparam int DIM_W      = 24;
	localparam int STRIDE_W   = 32;
	localparam int SRC_W      = 20;
	localparam int OFS_W      = 64;
	localparam int BX_W       = 23;
	localparam int REM_W      = 22;
	localparam int DIV_STAGES = BLK_W;
	localparam int PROD_W     = DIM_W + 1 + STRIDE_W + 1;
	localparam int CFG_IDX_W  = 8;
	localparam int CFG_DATA_W = 32;

	localparam logic [CFG_IDX_W-1:0] CFG_WIDTH    = 8'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT   = 8'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_X_STRIDE = 8'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_Y_STRIDE = 8'd3;

	typedef struct packed {
		logic [BLK_W-1:0]  block_index;
		logic [SLOT_W-1:0] batch_slot;
		logic [LEN_W-1:0]  batch_length;
	} blk_beat_t;

	typedef struct packed {
		logic [SRC_W-1:0]        source_index;
		logic signed [OFS_W-1:0] dest_offset;
		logic                    last;
		logic                    out_of_range;
	} addr_beat_t;

	typedef struct packed {
		logic [DIM_W-1:0]    width;
		logic [DIM_W-1:0]    height;
		logic [STRIDE_W-1:0] xs;
		logic [STRIDE_W-1:0] ys;
	} cfg_t;

	typedef struct packed {
		logic [BLK_W-1:0]  num;
		logic [REM_W-1:0]  rem;
		logic [SLOT_W-1:0] slot;
		logic [LEN_W-1:0]  len;
	} div_res_t;

	typedef struct packed {
		logic [OFS_W-1:0]  base;
		logic [OFS_W-1:0]  xs;
		logic [OFS_W-1:0]  ys;
		logic [SLOT_W-1:0] slot;
		logic [LEN_W-1:0]  len;
		logic [SIDE_W-1:0] lastx;
		logic [SIDE_W-1:0] lasty;
		logic              oor;
	} blk_desc_t;

endpackage

/* rtl/bsag_div_pipe.sv */
// ----------------------------------------------------------------------------
// Block index divider
// Restoring division of the block index by the blocks per row, one quotient
// bit per pipeline stage, carrying the batch fields alongside.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bsag_div_pipe
	import bsag_pkg::*;
(
	input  logic            clk,
	input  logic            arst_n,
	input  logic            en,
	input  logic            blk_valid,
	input  blk_beat_t       blk,
	input  logic [BX_W-1:0] bx,
	output logic            res_valid,
	output div_res_t        res
);

	logic [DIV_STAGES-1:0] v_s;
	div_res_t              d_s [DIV_STAGES];
	div_res_t              init;

	function automatic div_res_t div_step(div_res_t a, logic [BX_W-1:0] d);
		logic [BX_W-1:0] trial;
		div_res_t        r;
		r     = a;
		trial = {a.rem, a.num[BLK_W-1]};
		r.num = {a.num[BLK_W-2:0], 1'b0};
		if (trial >= d) begin
			trial    = trial - d;
			r.num[0] = 1'b1;
		end
		r.rem = trial[REM_W-1:0];
		return r;
	endfunction

	always_comb begin
		init.num  = blk.block_index;
		init.rem  = '0;
		init.slot = blk.batch_slot;
		init.len  = blk.batch_length;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s <= '0;
		end else if (en) begin
			v_s <= {v_s[DIV_STAGES-2:0], blk_valid};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			d_s[0] <= div_step(init, bx);
			for (int k = 1; k < DIV_STAGES; k++) begin
				d_s[k] <= div_step(d_s[k-1], bx);
			end
		end
	end

	assign res_valid = v_s[DIV_STAGES-1];
	assign res       = d_s[DIV_STAGES-1];

endmodule

/* rtl/bsag_origin.sv */
// ----------------------------------------------------------------------------
// Block origin and base offset
// Three stages: range check and effective strides, origin products and edge
// limits, then the base destination offset of the block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bsag_origin
	import bsag_pkg::*;
(
	input  logic            clk,
	input  logic            arst_n,
	input  logic            en,
	input  cfg_t            cfg,
	input  logic [BX_W-1:0] bx,
	input  logic            res_valid,
	input  div_res_t        res,
	output logic            desc_valid,
	output blk_desc_t       desc
);

	logic                       v_s1, v_s2, v_s3;
	logic                       oor_s1, oor_s2;
	logic [DIM_W-1:0]           x0_s1, y0_s1;
	logic signed [STRIDE_W:0]   xs_s1, ys_s1, xs_s2, ys_s2;
	logic [SLOT_W-1:0]          slot_s1, slot_s2;
	logic [LEN_W-1:0]           len_s1, len_s2;
	logic signed [PROD_W-1:0]   px_s2, py_s2;
	logic [SIDE_W-1:0]          lastx_s2, lasty_s2;
	blk_desc_t                  desc_s3;

	logic [BLK_W+SIDE_W-1:0]    q4;
	logic                       oor;
	logic signed [STRIDE_W:0]   xs_eff, ys_eff;
	logic [DIM_W-1:0]           dx, dy;
	logic [SIDE_W-1:0]          lastx, lasty;

	always_comb begin
		q4     = {res.num, 2'b00};
		oor    = (bx == '0) || (q4 >= (BLK_W + SIDE_W)'(cfg.height));
		xs_eff = (cfg.xs != '0) ? $signed({cfg.xs[STRIDE_W-1], cfg.xs})
		                        : (STRIDE_W + 1)'(1);
		ys_eff = (cfg.ys != '0) ? $signed({cfg.ys[STRIDE_W-1], cfg.ys})
		                        : $signed({{(STRIDE_W + 1 - DIM_W){1'b0}}, cfg.width});
	end

	always_comb begin
		dx    = cfg.width - x0_s1;
		dy    = cfg.height - y0_s1;
		lastx = (dx >= DIM_W'(BLOCK_SIDE)) ? SIDE_W'(BLOCK_SIDE - 1) : SIDE_W'(dx - 1'b1);
		lasty = (dy >= DIM_W'(BLOCK_SIDE)) ? SIDE_W'(BLOCK_SIDE - 1) : SIDE_W'(dy - 1'b1);
		if (oor_s1) begin
			lastx = '0;
			lasty = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s1 <= res_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			oor_s1  <= oor;
			x0_s1   <= {res.rem, 2'b00};
			y0_s1   <= {res.num[DIM_W-SIDE_W-1:0], 2'b00};
			xs_s1   <= xs_eff;
			ys_s1   <= ys_eff;
			slot_s1 <= res.slot;
			len_s1  <= res.len;

			px_s2    <= $signed({1'b0, x0_s1}) * xs_s1;
			py_s2    <= $signed({1'b0, y0_s1}) * ys_s1;
			lastx_s2 <= lastx;
			lasty_s2 <= lasty;
			oor_s2   <= oor_s1;
			xs_s2    <= xs_s1;
			ys_s2    <= ys_s1;
			slot_s2  <= slot_s1;
			len_s2   <= len_s1;

			desc_s3.base  <= {{(OFS_W - PROD_W){px_s2[PROD_W-1]}}, px_s2}
			               + {{(OFS_W - PROD_W){py_s2[PROD_W-1]}}, py_s2};
			desc_s3.xs    <= {{(OFS_W - STRIDE_W - 1){xs_s2[STRIDE_W]}}, xs_s2};
			desc_s3.ys    <= {{(OFS_W - STRIDE_W - 1){ys_s2[STRIDE_W]}}, ys_s2};
			desc_s3.slot  <= slot_s2;
			desc_s3.len   <= len_s2;
			desc_s3.lastx <= lastx_s2;
			desc_s3.lasty <= lasty_s2;
			desc_s3.oor   <= oor_s2;
		end
	end

	assign desc_valid = v_s3;
	assign desc       = desc_s3;

endmodule

/* rtl/bsag_expander.sv */
// ----------------------------------------------------------------------------
// Element expander
// Walks the in-array elements of one block in row-major order and issues
// one address beat per cycle from an output register while addr_ready is high.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module bsag_expander
	import bsag_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       desc_valid,
	input  blk_desc_t  desc,
	output logic       desc_ready,
	output logic       addr_valid,
	input  logic       addr_ready,
	output addr_beat_t addr
);

	logic              busy_q, out_valid_q;
	logic [SIDE_W-1:0] ix_q, iy_q;
	blk_desc_t         blk_q;
	logic [OFS_W-1:0]  cur_q, row_q;
	addr_beat_t        out_q;

	logic              fire, is_last, row_end, load;
	logic [OFS_W-1:0]  row_next;
	logic [SRC_W:0]    src;

	always_comb begin
		fire       = busy_q && (!out_valid_q || addr_ready);
		row_end    = (ix_q == blk_q.lastx);
		is_last    = row_end && (iy_q == blk_q.lasty);
		desc_ready = !busy_q || (fire && is_last);
		load       = desc_valid && desc_ready;
		row_next   = row_q + blk_q.ys;
		src        = (SRC_W + 1)'({iy_q, ix_q}) * (SRC_W + 1)'(blk_q.len)
		           + (SRC_W + 1)'(blk_q.slot);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			out_valid_q <= 1'b0;
			ix_q        <= '0;
			iy_q        <= '0;
		end else begin
			if (load) begin
				busy_q <= 1'b1;
			end else if (fire && is_last) begin
				busy_q <= 1'b0;
			end
			if (fire) begin
				out_valid_q <= 1'b1;
			end else if (addr_ready) begin
				out_valid_q <= 1'b0;
			end
			if (load) begin
				ix_q <= '0;
				iy_q <= '0;
			end else if (fire) begin
				if (row_end) begin
					ix_q <= '0;
					iy_q <= iy_q + 1'b1;
				end else begin
					ix_q <= ix_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			out_q.source_index <= blk_q.oor ? '0 : src[SRC_W-1:0];
			out_q.dest_offset  <= blk_q.oor ? '0 : $signed(cur_q);
			out_q.last         <= is_last;
			out_q.out_of_range <= blk_q.oor;
		end
		if (load) begin
			blk_q <= desc;
			cur_q <= desc.base;
			row_q <= desc.base;
		end else if (fire) begin
			if (row_end) begin
				row_q <= row_next;
				cur_q <= row_next;
			end else begin
				cur_q <= cur_q + blk_q.xs;
			end
		end
	end

	assign addr_valid = out_valid_q;
	assign addr       = out_q;

	`ASSERT_AR(a_oor_is_last, out_valid_q && out_q.out_of_range |-> out_q.last, "out-of-range beat not last")
	`ASSERT_AR(a_oor_zero, out_valid_q && out_q.out_of_range |-> out_q.source_index == '0 && out_q.dest_offset == '0, "out-of-range beat carries an address")
	`ASSERT_NEVER(a_walk_bounds, busy_q && (ix_q > blk_q.lastx || iy_q > blk_q.lasty), "element walk past block edge")

endmodule

/* rtl/block_scatter_address_generator_unit.sv */
// ----------------------------------------------------------------------------
// Block scatter address generator
// Turns one 4x4 block beat into the source and destination addresses of the
// block's elements that lie inside the configured array.
// ----------------------------------------------------------------------------
// A block beat passes a 44-stage divider (one quotient bit per stage) and a
// three-stage origin pipeline, then the expander's descriptor and output
// registers. The expander issues one address beat per cycle while addr_ready
// is high, one for each element of the block inside the array (1 to 16), or
// a single flagged beat for a block wholly outside the array. The pipeline
// keeps accepting blocks while the expander works, until a finished
// descriptor waits for the busy expander, which stalls every stage.
// Configuration writes are taken at once and must only be made while the
// block is idle.
`timescale 1ns / 1ps

module block_scatter_address_generator_unit
	import bsag_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  blk_valid,
	output logic                  blk_ready,
	input  blk_beat_t             blk,
	output logic                  addr_valid,
	input  logic                  addr_ready,
	output addr_beat_t            addr
);

	logic [DIM_W-1:0]    width_q, height_q;
	logic [STRIDE_W-1:0] xs_q, ys_q;
	cfg_t                cfg;
	logic [DIM_W:0]      w3;
	logic [BX_W-1:0]     bx;
	logic                en;
	logic                res_valid, desc_valid, desc_ready;
	div_res_t            res;
	blk_desc_t           desc;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= DIM_W'(1);
			height_q <= DIM_W'(1);
			xs_q     <= '0;
			ys_q     <= '0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_WIDTH: begin
					width_q <= cfg_data[DIM_W-1:0];
				end
				CFG_HEIGHT: begin
					height_q <= cfg_data[DIM_W-1:0];
				end
				CFG_X_STRIDE: begin
					xs_q <= cfg_data;
				end
				CFG_Y_STRIDE: begin
					ys_q <= cfg_data;
				end
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		cfg.width  = width_q;
		cfg.height = height_q;
		cfg.xs     = xs_q;
		cfg.ys     = ys_q;
		w3         = {1'b0, width_q} + (DIM_W + 1)'(BLOCK_SIDE - 1);
		bx         = w3[DIM_W:SIDE_W];
	end

	assign en        = !desc_valid || desc_ready;
	assign blk_ready = en;

	bsag_div_pipe u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.blk_valid (blk_valid),
		.blk       (blk),
		.bx        (bx),
		.res_valid (res_valid),
		.res       (res)
	);

	bsag_origin u_origin (
		.clk        (clk),
		.arst_n     (arst_n),
		.en         (en),
		.cfg        (cfg),
		.bx         (bx),
		.res_valid  (res_valid),
		.res        (res),
		.desc_valid (desc_valid),
		.desc       (desc)
	);

	bsag_expander u_expander (
		.clk        (clk),
		.arst_n     (arst_n),
		.desc_valid (desc_valid),
		.desc       (desc),
		.desc_ready (desc_ready),
		.addr_valid (addr_valid),
		.addr_ready (addr_ready),
		.addr       (addr)
	);

endmodule
